>>> sv/a128cm_pkg.sv
// ----------------------------------------------------------------------------
// a128cm_pkg
// Shared types, register codes and AES-128 round functions for the CBC-MAC.
// ----------------------------------------------------------------------------
package a128cm_pkg;

  localparam int unsigned RegCount = 4;
  localparam int unsigned AddrW    = 5;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } out_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block is bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(blk_t b, int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the previous one; rnd is 1..10.
  function automatic blk_t next_rkey(blk_t k, int unsigned rnd);
    logic [31:0] w [4];
    logic [31:0] t;
    blk_t        r;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    t = {SBOX[w[3][23:16]] ^ RCON[rnd], SBOX[w[3][15:8]], SBOX[w[3][7:0]],
         SBOX[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    return r;
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey.
  function automatic blk_t aes_round(blk_t st, blk_t rk, logic final_rnd);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    blk_t       r;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        t[row+4*c] = SBOX[get_byte(st, row + 4*((c+row) % 4))];
      end
    end
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r ^ rk;
  endfunction

endpackage

>>> sv/a128cm_if.sv
// ----------------------------------------------------------------------------
// a128cm_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface a128cm_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/aes128_cbc_mac_top.sv
// ----------------------------------------------------------------------------
// aes128_cbc_mac_top
// AES-128 CBC-MAC over whole 16-byte blocks with an APB register port.
// ----------------------------------------------------------------------------
// Usage: blocks enter on in_ch (block_high, block_low, last_block). The chain
// restarts from the IV registers at the first block of each message. Only a
// block marked last produces a transfer on out_ch, carrying the MAC.
// Registers: key_high 0x00, key_low 0x08, iv_high 0x10, iv_low 0x18, 64 bits.
// Pipeline: the accepted block is held in the input register and encrypted
// by ten unrolled rounds feeding the chain register; a last block's MAC is
// loaded into the result register for out_ch. Throughput: one block per cycle
// while no last block waits on a full result register; the chain feedback
// through all ten rounds and the on-the-fly key schedule sets the clock.
// Reset clears registers, the chain and the pipeline; the first block then
// starts a new message. When the receiver stalls, the output register holds
// the MAC and input is still taken while the stage in front is free or will
// move on; a second pending MAC stops input until the output drains.
// ----------------------------------------------------------------------------
module aes128_cbc_mac_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  a128cm_if.sink                        in_ch,
  a128cm_if.source                      out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [a128cm_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import a128cm_pkg::*;

  logic [63:0] regs_q [RegCount];
  logic [1:0]  ridx;
  logic        wr_en;

  assign pready = 1'b1;
  assign ridx   = paddr[4:3];
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'b000);
  assign prdata = regs_q[ridx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) regs_q[i] <= '0;
    end else if (wr_en) begin
      regs_q[ridx] <= pwdata;
    end
  end

  // Input stage: block xored later with the chain; key and iv sampled here.
  logic       s1_vld_q, s1_last_q, s1_start_q;
  blk_t       s1_blk_q, s1_key_q, s1_iv_q;
  logic       start_q;
  blk_t       chain_q;
  logic       res_vld_q;
  out_item_t  res_q;
  logic       s1_adv, in_fire, res_free;

  // Result register frees when empty or being taken.
  assign res_free    = !res_vld_q || out_ch.ready;
  assign s1_adv      = !s1_vld_q || !s1_last_q || res_free;
  assign in_ch.ready = s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      start_q  <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= in_fire;
      if (in_fire) start_q <= in_ch.data.last_block;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_blk_q   <= {in_ch.data.block_high, in_ch.data.block_low};
      s1_last_q  <= in_ch.data.last_block;
      s1_start_q <= start_q;
      s1_key_q   <= {regs_q[REG_KEY_HIGH], regs_q[REG_KEY_LOW]};
      s1_iv_q    <= {regs_q[REG_IV_HIGH], regs_q[REG_IV_LOW]};
    end
  end

  blk_t st  [11];
  blk_t rk  [11];
  blk_t cipher;

  always_comb begin
    rk[0] = s1_key_q;
    st[0] = s1_blk_q ^ (s1_start_q ? s1_iv_q : chain_q) ^ s1_key_q;
    for (int r = 1; r <= 10; r++) begin
      rk[r] = next_rkey(rk[r-1], r);
      st[r] = aes_round(st[r-1], rk[r], r == 10);
    end
    cipher = st[10];
  end

  logic s1_done;
  assign s1_done = s1_vld_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (s1_done) chain_q <= cipher;
      if (s1_done && s1_last_q) res_vld_q <= 1'b1;
      else if (out_ch.ready) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_last_q) res_q <= {cipher[127:64], cipher[63:0]};
  end

  assign out_ch.valid = res_vld_q;
  assign out_ch.data  = res_q;

endmodule

>>> test/aes128_cbc_mac_top_tb.sv
// ----------------------------------------------------------------------------
// aes128_cbc_mac_top_tb
// Drives message blocks into the CBC-MAC, computes each expected MAC with an
// independent AES-128 model, and checks every output transfer in order.
// ----------------------------------------------------------------------------
module aes128_cbc_mac_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import a128cm_pkg::*;

  localparam logic [7:0] SUB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam int unsigned MaxCycles = 400000;

  function automatic logic [7:0] gf_double(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Plain byte-array AES-128 encryption; byte 0 is the top byte of the vector.
  function automatic logic [127:0] aes_encrypt(logic [127:0] key, logic [127:0] pt);
    logic [7:0] ks [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] s, b0, b1, b2, b3, sum;
    logic [7:0] rc;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      ks[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ ks[i];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = ks[i-4+j];
      if (i % 16 == 0) begin
        s = w[0];
        w[0] = SUB[w[1]] ^ rc;
        w[1] = SUB[w[2]];
        w[2] = SUB[w[3]];
        w[3] = SUB[s];
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) ks[i+j] = ks[i-16+j] ^ w[j];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++) tmp[row+4*c] = SUB[st[row+4*((c+row)%4)]];
      st = tmp;
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          b0 = st[4*c]; b1 = st[4*c+1]; b2 = st[4*c+2]; b3 = st[4*c+3];
          sum = b0 ^ b1 ^ b2 ^ b3;
          st[4*c]   = b0 ^ sum ^ gf_double(b0 ^ b1);
          st[4*c+1] = b1 ^ sum ^ gf_double(b1 ^ b2);
          st[4*c+2] = b2 ^ sum ^ gf_double(b2 ^ b3);
          st[4*c+3] = b3 ^ sum ^ gf_double(b3 ^ b0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ ks[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  class mac_scoreboard;
    logic [63:0] regs [RegCount];
    logic [127:0] chain;
    bit fresh_msg;
    out_item_t pending_macs [$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      chain = '0;
      fresh_msg = 1;
      errors = 0;
    endfunction

    function void note_block(in_item_t it);
      if (fresh_msg) chain = {regs[REG_IV_HIGH], regs[REG_IV_LOW]};
      chain = aes_encrypt({regs[REG_KEY_HIGH], regs[REG_KEY_LOW]},
                          {it.block_high, it.block_low} ^ chain);
      fresh_msg = it.last_block;
      if (it.last_block) pending_macs.push_back('{chain[127:64], chain[63:0]});
    endfunction

    function void check_mac(out_item_t got);
      out_item_t exp_mac;
      if (pending_macs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected MAC %h %h", got.mac_high, got.mac_low);
        return;
      end
      exp_mac = pending_macs.pop_front();
      if (got.mac_high !== exp_mac.mac_high || got.mac_low !== exp_mac.mac_low) begin
        errors++;
        if (errors <= 10)
          $display("MAC mismatch: exp %h %h got %h %h", exp_mac.mac_high,
                   exp_mac.mac_low, got.mac_high, got.mac_low);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit stall_enable = 1;
  mac_scoreboard sb = new();

  a128cm_if #(.T(in_item_t)) blk_ch ();
  a128cm_if #(.T(out_item_t)) mac_ch ();

  aes128_cbc_mac_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(blk_ch.sink), .out_ch(mac_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    blk_ch.valid = 0;
    blk_ch.data = '0;
    mac_ch.ready = 0;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver side: random stalls of varying length, checks on every transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mac_ch.valid && mac_ch.ready) sb.check_mac(mac_ch.data);
      if (stall_left != 0) begin
        mac_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        mac_ch.ready <= 1'b0;
        stall_left <= gap_len();
      end else begin
        mac_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycles) begin
      $display("aes128_cbc_mac_top_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= AddrW'(8 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.regs[idx] = val;
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // Valid stays high after a transfer when the next block follows at once.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic last);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      blk_ch.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    blk_ch.valid <= 1;
    blk_ch.data <= '{hi, lo, last};
    do @(posedge clk_i); while (!blk_ch.ready);
    sb.note_block('{hi, lo, last});
  endtask

  task automatic drain();
    blk_ch.valid <= 0;
    while (sb.pending_macs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_message(int unsigned nblk);
    for (int unsigned i = 0; i < nblk; i++)
      send_block(rand64(), rand64(), i == nblk - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset values: zero key and IV, then all-ones and the standard test key.
    send_block('0, '0, 1);
    send_block('1, '1, 1);
    drain();
    write_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, '1);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1);
    send_block(64'h8000000000000001, 64'h0000000000000001, 0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 0);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1);
    drain();
    // Key changes mid-message; an IV write only takes effect on the next message.
    send_block(rand64(), rand64(), 0);
    drain();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_IV_HIGH, '0);
    write_reg(REG_IV_LOW, 64'h1);
    send_block(rand64(), rand64(), 1);
    send_block('1, '0, 1);
    drain();

    sent = 0;
    while (sent < 800) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_LOW, rand64());
        write_reg(REG_IV_HIGH, rand64());
        write_reg(REG_IV_LOW, rand64());
        stall_enable = ($urandom_range(0, 3) != 0);
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      random_message(n);
      sent += n;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_macs.size() == 0) begin
      $display("aes128_cbc_mac_top_tb: PASS");
    end else begin
      $display("aes128_cbc_mac_top_tb: FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/a128cm_pkg.sv
sv/a128cm_if.sv
sv/aes128_cbc_mac_top.sv
test/aes128_cbc_mac_top_tb.sv
